// ----- src/rset_pkg.sv -----
// Shared types and constants for the randomized set table.
`timescale 1ns / 1ps

package rset_pkg;

  // Default store depth
  localparam int unsigned CapacityDef = 1024;

  // Request kinds; any kind with the upper bit set is a random pick
  localparam logic [1:0] ReqInsert = 2'd0;
  localparam logic [1:0] ReqRemove = 2'd1;

  // Response status codes
  typedef enum logic [1:0] {
    StDone     = 2'd0,
    StPresence = 2'd1,
    StFull     = 2'd2,
    StEmpty    = 2'd3
  } status_e;

  // Request payload
  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] value;
    logic [31:0]        random_word;
  } req_t;

  // Response payload
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] picked_value;
    logic [10:0]        member_count;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    accept;     // latch request, reset scan and divider
    logic    scan_step;  // issue next search read
    logic    div_step;   // one remainder bit
    logic    pick_rd;    // read entry at the remainder
    logic    last_rd;    // read last member
    logic    move_wr;    // last member into hit slot, count down
    logic    append_wr;  // write value at end, count up
    logic    load_out;   // load response register
    status_e status;     // status for the response
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_rand;     // incoming request is a random pick
    logic empty;       // member count is zero
    logic full;        // member count at capacity
    logic req_insert;  // latched request is an insert
    logic hit;         // search found the value
    logic miss;        // search finished without a match
    logic div_last;    // divider on its final bit
    logic out_busy;    // response register holds an untaken response
  } sts_t;

endpackage

// ----- src/rset_ctrl.sv -----
// Sequencing state machine for the randomized set table.
`timescale 1ns / 1ps

module rset_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rset_pkg::sts_t sts_i,
  output rset_pkg::cmd_t cmd_o
);
  import rset_pkg::*;

  typedef enum logic [7:0] {
    SIdle   = 8'b0000_0001,
    SSearch = 8'b0000_0010,
    SDivide = 8'b0000_0100,
    SPickRd = 8'b0000_1000,
    SMoveRd = 8'b0001_0000,
    SMoveWr = 8'b0010_0000,
    SAppend = 8'b0100_0000,
    SFinish = 8'b1000_0000
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;

  assign in_ready_o = (state_q == SIdle);

  // Next state and command decode
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.status = status_q;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          status_d     = StDone;
          if (sts_i.in_rand) begin
            if (sts_i.empty) begin
              status_d = StEmpty;
              state_d  = SFinish;
            end else begin
              state_d = SDivide;
            end
          end else begin
            state_d = SSearch;
          end
        end
      end
      SSearch: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit) begin
          if (sts_i.req_insert) begin
            status_d = StPresence;
            state_d  = SFinish;
          end else begin
            state_d = SMoveRd;
          end
        end else if (sts_i.miss) begin
          if (!sts_i.req_insert) begin
            status_d = StPresence;
            state_d  = SFinish;
          end else if (sts_i.full) begin
            status_d = StFull;
            state_d  = SFinish;
          end else begin
            state_d = SAppend;
          end
        end
      end
      SDivide: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = SPickRd;
        end
      end
      SPickRd: begin
        cmd_o.pick_rd = 1'b1;
        state_d       = SFinish;
      end
      SMoveRd: begin
        cmd_o.last_rd = 1'b1;
        state_d       = SMoveWr;
      end
      SMoveWr: begin
        cmd_o.move_wr = 1'b1;
        state_d       = SFinish;
      end
      SAppend: begin
        cmd_o.append_wr = 1'b1;
        state_d         = SFinish;
      end
      SFinish: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      status_q <= StDone;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

// ----- src/rset_dp.sv -----
// Datapath for the randomized set table: member store, search, divider, response.
`timescale 1ns / 1ps

module rset_dp #(
  parameter int unsigned CAPACITY = rset_pkg::CapacityDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rset_pkg::req_t in_req_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output rset_pkg::rsp_t out_rsp_o,
  input  rset_pkg::cmd_t cmd_i,
  output rset_pkg::sts_t sts_o
);
  import rset_pkg::*;

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  // Member store
  logic [31:0] mem_q [CAPACITY];
  logic [31:0] rd_data_q;
  logic        mem_we, mem_re;
  logic [AddrW-1:0] mem_wa, mem_ra;
  logic [31:0] mem_wd;

  // Control and payload registers
  req_t            req_q;
  logic [CntW-1:0] total_q, total_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic [CntW-1:0] cmp_idx_q;
  logic            cmp_vld_q, cmp_vld_d;
  logic [AddrW-1:0] slot_q;
  logic [CntW-1:0] rem_q, rem_d;
  logic [4:0]      div_cnt_q, div_cnt_d;
  rsp_t            out_q;
  logic            out_vld_q, out_vld_d;

  logic            scan_issue;
  logic            hit;
  logic [CntW:0]   div_trial;
  logic [CntW-1:0] last_idx;
  logic [CntW+10:0] cnt_ext;

  assign scan_issue = cmd_i.scan_step && (scan_q < total_q);
  assign hit        = cmp_vld_q && (rd_data_q == req_q.value);
  assign last_idx   = total_q - CntW'(1);
  assign div_trial  = {rem_q, req_q.random_word[div_cnt_q]};
  assign cnt_ext    = {11'd0, total_q};

  // Status to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.in_rand    = in_req_i.req_type[1];
    sts_o.empty      = (total_q == '0);
    sts_o.full       = (total_q >= CntW'(CAPACITY));
    sts_o.req_insert = (req_q.req_type == ReqInsert);
    sts_o.hit        = hit;
    sts_o.miss       = !cmp_vld_q && (scan_q >= total_q);
    sts_o.div_last   = (div_cnt_q == 5'd0);
    sts_o.out_busy   = out_vld_q && !out_ready_i;
  end

  // Memory port selection
  always_comb begin
    mem_re = scan_issue || cmd_i.pick_rd || cmd_i.last_rd;
    if (cmd_i.pick_rd) begin
      mem_ra = rem_q[AddrW-1:0];
    end else if (cmd_i.last_rd) begin
      mem_ra = last_idx[AddrW-1:0];
    end else begin
      mem_ra = scan_q[AddrW-1:0];
    end
    mem_we = cmd_i.append_wr || cmd_i.move_wr;
    if (cmd_i.move_wr) begin
      mem_wa = slot_q;
      mem_wd = rd_data_q;
    end else begin
      mem_wa = total_q[AddrW-1:0];
      mem_wd = req_q.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem_q[mem_ra];
    end
  end

  // Scan, divider and count next values
  always_comb begin
    scan_d    = scan_q;
    cmp_vld_d = scan_issue;
    rem_d     = rem_q;
    div_cnt_d = div_cnt_q;
    total_d   = total_q;
    if (cmd_i.accept) begin
      scan_d    = '0;
      cmp_vld_d = 1'b0;
      rem_d     = '0;
      div_cnt_d = 5'd31;
    end
    if (scan_issue) begin
      scan_d = scan_q + CntW'(1);
    end
    // restoring remainder step, one dividend bit per cycle
    if (cmd_i.div_step) begin
      if (div_trial >= {1'b0, total_q}) begin
        rem_d = CntW'(div_trial - {1'b0, total_q});
      end else begin
        rem_d = div_trial[CntW-1:0];
      end
      div_cnt_d = div_cnt_q - 5'd1;
    end
    if (cmd_i.append_wr) begin
      total_d = total_q + CntW'(1);
    end else if (cmd_i.move_wr) begin
      total_d = last_idx;
    end
  end

  // Response register
  always_comb begin
    out_vld_d = out_vld_q && !out_ready_i;
    if (cmd_i.load_out) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      div_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      total_q   <= total_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      div_cnt_q <= div_cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_req_i;
    end
    if (scan_issue) begin
      cmp_idx_q <= scan_q;
    end
    if (cmd_i.scan_step && hit) begin
      slot_q <= cmp_idx_q[AddrW-1:0];
    end
    rem_q <= rem_d;
    if (cmd_i.load_out) begin
      out_q.status       <= cmd_i.status;
      out_q.picked_value <= (req_q.req_type[1] && cmd_i.status == StDone) ?
                            rd_data_q : 32'sd0;
      out_q.member_count <= cnt_ext[10:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(CAPACITY))
    else $error("member count above capacity");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_vld_q && !out_ready_i))
    else $error("response loaded over an untaken response");

  a_append_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append_wr |=> total_q == $past(total_q) + CntW'(1))
    else $error("append did not grow the count");

  a_move_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.move_wr |=> total_q == $past(total_q) - CntW'(1))
    else $error("remove did not shrink the count");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> cmp_idx_q < total_q)
    else $error("search matched outside the occupied entries");
`endif

endmodule

// ----- src/randomized_set_table_unit.sv -----
// Top level of the randomized set table.
`timescale 1ns / 1ps

// Holds a set of distinct 32-bit signed values in a dense store of CAPACITY
// entries, with one read port and one write port, and a member count. Insert
// appends an absent value, remove swaps the last member into the removed
// slot, and a random request returns the member at random_word modulo the
// count. Insert and remove search the store one entry per cycle through the
// single read port. A random request runs a one-bit-per-cycle remainder unit
// over the 32-bit random word, or returns an empty status on an empty set.
// One request is in flight at a time; the response register lets the next
// request be taken while a response waits. The store needs no clearing
// after reset.
module randomized_set_table_unit #(
  parameter int unsigned CAPACITY = rset_pkg::CapacityDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rset_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rset_pkg::rsp_t out_rsp_o
);
  import rset_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rset_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rset_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
